// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: default sizes, the configuration register
// layout, access codes and the command control struct.
// No dependencies.
package lkvc_pkg;

	localparam int unsigned LKVC_ENTRIES     = 16;
	localparam int unsigned LKVC_KEY_WIDTH   = 16;
	localparam int unsigned LKVC_VALUE_WIDTH = 32;

	// Command queue between the front and the back.
	localparam int unsigned LKVC_QUEUE_DEPTH = 2;

	// Capacity register.
	localparam int unsigned CAP_WIDTH = 5;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

	// Access codes carried on the mode field.
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// What the back has to do with one classified access.
	typedef struct packed {
		logic rd_en;    // get that hit: read the stored value
		logic wr_en;    // put: write the value into the slot
		logic hit;
		logic evicted;
	} lkvc_ctrl_t;

endpackage

// ===== rtl/lkvc_front.sv =====
// Front of the LRU key-value cache: takes access beats, matches the key against
// the tag store, keeps recency ranks and entry count, and issues commands.
// Depends on lkvc_pkg.
module lkvc_front
	import lkvc_pkg::*;
#(
	parameter int unsigned ENTRIES     = LKVC_ENTRIES,
	parameter int unsigned KEY_WIDTH   = LKVC_KEY_WIDTH,
	parameter int unsigned VALUE_WIDTH = LKVC_VALUE_WIDTH,
	localparam int unsigned SW = $clog2(ENTRIES),
	localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CAP_WIDTH-1:0]   cfg_write_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   cmd_valid,
	input  logic                   cmd_ready,
	output lkvc_ctrl_t             cmd_ctrl,
	output logic [SW-1:0]          cmd_slot,
	output logic [KEY_WIDTH-1:0]   cmd_evicted_key,
	output logic [VALUE_WIDTH-1:0] cmd_value
);

	localparam int unsigned CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

	logic [CAP_WIDTH-1:0] capacity_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [KEY_WIDTH-1:0] keys_q [ENTRIES];
	logic [SW-1:0]        rank_q [ENTRIES];
	logic [CW-1:0]        count_q;

	logic                 accept;
	logic                 hit_found;
	logic [SW-1:0]        hit_slot;
	logic [SW-1:0]        hit_rank;
	logic [SW-1:0]        victim_slot;
	logic [SW-1:0]        free_slot;
	logic [SW-1:0]        lru_rank;
	logic [CMPW-1:0]      cap_ext;
	logic [CMPW-1:0]      eff_cap;
	logic                 full;
	logic                 is_put;
	logic                 insert;
	logic                 evict;
	logic                 touch;
	logic [SW-1:0]        slot;

	assign accept    = in_valid && cmd_ready;
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;

	// The least recent valid entry always holds rank count-1.
	assign lru_rank = SW'(count_q - CW'(1));

	always_comb begin
		hit_found   = 1'b0;
		hit_slot    = '0;
		victim_slot = '0;
		free_slot   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && keys_q[i] == key) begin
				hit_found = 1'b1;
				hit_slot  = SW'(i);
			end
			if (valid_q[i] && rank_q[i] == lru_rank) begin
				victim_slot = SW'(i);
			end
			if (!valid_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	always_comb begin
		cap_ext = CMPW'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > CMPW'(ENTRIES)) begin
			eff_cap = CMPW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full     = CMPW'(count_q) >= eff_cap;
	assign hit_rank = rank_q[hit_slot];
	assign is_put   = (mode == MODE_PUT);
	assign insert   = is_put && !hit_found;
	assign evict    = insert && full;
	assign touch    = accept && (hit_found || insert);
	assign slot     = hit_found ? hit_slot : (full ? victim_slot : free_slot);

	always_comb begin
		cmd_ctrl.rd_en   = !is_put && hit_found;
		cmd_ctrl.wr_en   = is_put;
		cmd_ctrl.hit     = hit_found;
		cmd_ctrl.evicted = evict;
	end

	assign cmd_slot        = slot;
	assign cmd_evicted_key = evict ? keys_q[victim_slot] : '0;
	assign cmd_value       = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			valid_q    <= '0;
			count_q    <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				capacity_q <= cfg_write_data;
			end
			if (touch) begin
				// A hit ages only the entries newer than it; an insert ages all others.
				for (int i = 0; i < ENTRIES; i++) begin
					if (SW'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (insert || rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + SW'(1);
					end
				end
			end
			if (accept && insert) begin
				valid_q[slot] <= 1'b1;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && insert) begin
			keys_q[slot] <= key;
		end
	end

endmodule

// ===== rtl/lkvc_queue.sv =====
// Command queue of the LRU key-value cache: a small FIFO that lets the front
// and the back stall independently.
// Depends on lkvc_pkg.
module lkvc_queue
	import lkvc_pkg::*;
#(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = LKVC_QUEUE_DEPTH,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != NW'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data  = data_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ===== rtl/lkvc_back.sv =====
// Back of the LRU key-value cache: owns the value memory, carries out the reads
// and writes of each command and holds the result register.
// Depends on lkvc_pkg.
module lkvc_back
	import lkvc_pkg::*;
#(
	parameter int unsigned ENTRIES     = LKVC_ENTRIES,
	parameter int unsigned KEY_WIDTH   = LKVC_KEY_WIDTH,
	parameter int unsigned VALUE_WIDTH = LKVC_VALUE_WIDTH,
	localparam int unsigned SW = $clog2(ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  lkvc_ctrl_t             cmd_ctrl,
	input  logic [SW-1:0]          cmd_slot,
	input  logic [KEY_WIDTH-1:0]   cmd_evicted_key,
	input  logic [VALUE_WIDTH-1:0] cmd_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [VALUE_WIDTH-1:0] read_value,
	output logic                   evicted,
	output logic [KEY_WIDTH-1:0]   evicted_key
);

	logic [VALUE_WIDTH-1:0] mem [ENTRIES];

	logic                   valid_s1;
	lkvc_ctrl_t             ctrl_s1;
	logic [KEY_WIDTH-1:0]   evk_s1;
	logic [VALUE_WIDTH-1:0] rdata_s1;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] read_value_q;
	logic                   evicted_q;
	logic [KEY_WIDTH-1:0]   evicted_key_q;

	logic                   adv_s1;
	logic                   pop;

	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Commands leave the queue in order, so a read always sees earlier writes.
	always_ff @(posedge clk) begin
		if (pop && cmd_ctrl.wr_en) begin
			mem[cmd_slot] <= cmd_value;
		end
		if (pop && cmd_ctrl.rd_en) begin
			rdata_s1 <= mem[cmd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_s1 <= cmd_ctrl;
			evk_s1  <= cmd_evicted_key;
		end
		if (adv_s1) begin
			hit_q         <= ctrl_s1.hit;
			read_value_q  <= ctrl_s1.rd_en ? rdata_s1 : '0;
			evicted_q     <= ctrl_s1.evicted;
			evicted_key_q <= evk_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

// ===== rtl/lru_key_value_cache_core.sv =====
// Top level of the LRU key-value cache: front, command queue and back.
// Depends on lkvc_pkg, lkvc_front, lkvc_queue and lkvc_back.
//
//   channel   handshake               payload
//   -------   ---------------------   ----------------------------------------
//   in        in_valid / in_ready     mode, key, value
//   out       out_valid / out_ready   hit, read_value, evicted, evicted_key
//   cfg       cfg_write_en            cfg_write_data (capacity_in_use)
//
// One access beat is taken per cycle while in_ready is high; the tag match and rank update
// in the front sets that figure. A result beat passes through the queue, the value
// memory read and the result register on its way out.
// Reset clears valid bits, ranks, count and queue; keys and values are not reset.
// A stalled result fills the back and then the queue before in_ready falls.
module lru_key_value_cache_core
	import lkvc_pkg::*;
#(
	parameter int unsigned ENTRIES     = LKVC_ENTRIES,
	parameter int unsigned KEY_WIDTH   = LKVC_KEY_WIDTH,
	parameter int unsigned VALUE_WIDTH = LKVC_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CAP_WIDTH-1:0]   cfg_write_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [KEY_WIDTH-1:0]   key,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [VALUE_WIDTH-1:0] read_value,
	output logic                   evicted,
	output logic [KEY_WIDTH-1:0]   evicted_key
);

	localparam int unsigned SW = $clog2(ENTRIES);
	localparam int unsigned CTW = $bits(lkvc_ctrl_t);
	localparam int unsigned QW = CTW + SW + KEY_WIDTH + VALUE_WIDTH;

	logic                   f_valid;
	logic                   f_ready;
	lkvc_ctrl_t             f_ctrl;
	logic [SW-1:0]          f_slot;
	logic [KEY_WIDTH-1:0]   f_evk;
	logic [VALUE_WIDTH-1:0] f_value;

	logic                   b_valid;
	logic                   b_ready;
	logic [QW-1:0]          b_data;
	lkvc_ctrl_t             b_ctrl;
	logic [SW-1:0]          b_slot;
	logic [KEY_WIDTH-1:0]   b_evk;
	logic [VALUE_WIDTH-1:0] b_value;

	lkvc_front #(
		.ENTRIES    (ENTRIES),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.key            (key),
		.value          (value),
		.cmd_valid      (f_valid),
		.cmd_ready      (f_ready),
		.cmd_ctrl       (f_ctrl),
		.cmd_slot       (f_slot),
		.cmd_evicted_key(f_evk),
		.cmd_value      (f_value)
	);

	lkvc_queue #(
		.WIDTH(QW),
		.DEPTH(LKVC_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_data  ({f_ctrl, f_slot, f_evk, f_value}),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_data (b_data)
	);

	assign b_ctrl  = lkvc_ctrl_t'(b_data[QW-1 -: CTW]);
	assign b_slot  = b_data[KEY_WIDTH + VALUE_WIDTH +: SW];
	assign b_evk   = b_data[VALUE_WIDTH +: KEY_WIDTH];
	assign b_value = b_data[VALUE_WIDTH-1:0];

	lkvc_back #(
		.ENTRIES    (ENTRIES),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (b_valid),
		.cmd_ready      (b_ready),
		.cmd_ctrl       (b_ctrl),
		.cmd_slot       (b_slot),
		.cmd_evicted_key(b_evk),
		.cmd_value      (b_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.read_value     (read_value),
		.evicted        (evicted),
		.evicted_key    (evicted_key)
	);

endmodule

// ===== tb/lru_key_value_cache_core_checker.sv =====
// Scoreboard for the LRU key-value cache: keeps its own copy of the store and
// recency order, predicts each result from the access beats and compares.
// Depends on lkvc_pkg for the field widths, capacity layout and access codes.
module lru_key_value_cache_core_checker
	import lkvc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [CAP_WIDTH-1:0]        cfg_write_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        mode,
	input  logic [LKVC_KEY_WIDTH-1:0]   key,
	input  logic [LKVC_VALUE_WIDTH-1:0] value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        hit,
	input  logic [LKVC_VALUE_WIDTH-1:0] read_value,
	input  logic                        evicted,
	input  logic [LKVC_KEY_WIDTH-1:0]   evicted_key,
	output int                          failures,
	output int                          pending
);

	typedef struct packed {
		logic                        hit;
		logic [LKVC_VALUE_WIDTH-1:0] read_value;
		logic                        evicted;
		logic [LKVC_KEY_WIDTH-1:0]   evicted_key;
	} access_result_t;

	logic [LKVC_KEY_WIDTH-1:0]   line_key   [LKVC_ENTRIES];
	logic [LKVC_VALUE_WIDTH-1:0] line_value [LKVC_ENTRIES];
	bit                          line_valid [LKVC_ENTRIES];
	int unsigned                 line_age   [LKVC_ENTRIES];
	int unsigned                 lines_held;
	logic [CAP_WIDTH-1:0]        capacity;
	access_result_t              awaited_results [$];
	access_result_t              want;
	int                          mismatch_count;

	// Age zero is the newest line; only valid lines younger than the limit get older.
	function automatic void make_newest(input int unsigned slot, input int unsigned limit);
		for (int i = 0; i < LKVC_ENTRIES; i++)
			if (line_valid[i] && i != slot && line_age[i] < limit)
				line_age[i]++;
		line_age[slot] = 0;
	endfunction

	function automatic access_result_t look_up_and_update(
		input logic                        op,
		input logic [LKVC_KEY_WIDTH-1:0]   k,
		input logic [LKVC_VALUE_WIDTH-1:0] v
	);
		access_result_t r;
		int unsigned    slot;
		int unsigned    room;
		int unsigned    oldest_age;
		bit             found;
		r = '0;
		slot = LKVC_ENTRIES;
		found = 1'b0;
		oldest_age = 0;
		for (int i = 0; i < LKVC_ENTRIES; i++)
			if (line_valid[i] && line_key[i] == k && slot == LKVC_ENTRIES)
				slot = i;
		if (slot < LKVC_ENTRIES) begin
			r.hit = 1'b1;
			if (op == MODE_GET)
				r.read_value = line_value[slot];
			else
				line_value[slot] = v;
			make_newest(slot, line_age[slot]);
		end else if (op == MODE_PUT) begin
			// A capacity of zero behaves as one, anything above the store size as full size.
			room = (capacity == 0) ? 1 : ((capacity > LKVC_ENTRIES) ? LKVC_ENTRIES : capacity);
			if (lines_held >= room) begin
				for (int i = 0; i < LKVC_ENTRIES; i++)
					if (line_valid[i] && (!found || line_age[i] > oldest_age)) begin
						slot = i;
						oldest_age = line_age[i];
						found = 1'b1;
					end
				if (found) begin
					r.evicted = 1'b1;
					r.evicted_key = line_key[slot];
					line_valid[slot] = 1'b0;
					lines_held--;
				end
			end
			if (slot == LKVC_ENTRIES)
				for (int i = 0; i < LKVC_ENTRIES; i++)
					if (!line_valid[i] && slot == LKVC_ENTRIES)
						slot = i;
			if (slot < LKVC_ENTRIES) begin
				line_key[slot] = k;
				line_value[slot] = v;
				line_valid[slot] = 1'b1;
				lines_held++;
				make_newest(slot, LKVC_ENTRIES + 1);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LKVC_ENTRIES; i++) begin
				line_key[i] = '0;
				line_value[i] = '0;
				line_valid[i] = 1'b0;
				line_age[i] = 0;
			end
			lines_held = 0;
			capacity = CAP_RESET;
			awaited_results.delete();
			mismatch_count = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_write_en)
				capacity = cfg_write_data;
			if (in_valid && in_ready)
				awaited_results.push_back(look_up_and_update(mode, key, value));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat arrived with no access outstanding");
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						mismatch_count++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value, read_value);
						mismatch_count++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, evicted);
						mismatch_count++;
					end
					if (evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
						mismatch_count++;
					end
				end
			end
			failures <= mismatch_count;
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== tb/lru_key_value_cache_core_test.sv =====
// Top of the LRU key-value cache testbench: clock, reset, access and capacity
// stimulus, result back-pressure, watchdog and verdict.
// Depends on lkvc_pkg, lru_key_value_cache_core and lru_key_value_cache_core_checker.
module lru_key_value_cache_core_test;
	import lkvc_pkg::*;

	localparam int unsigned ITEMS_PER_PHASE = 60;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned BURST_ITEMS     = 20;
	localparam int unsigned HOLD_CYCLES     = 60;
	localparam int unsigned QUIET_LIMIT     = 2000;
	localparam int unsigned DRAIN_CYCLES    = 10;
	// Capacity for each random phase, phase 0 in the lowest five bits.
	localparam logic [PHASES*CAP_WIDTH-1:0] PHASE_CAPS =
		{5'd2, 5'd8, 5'd17, 5'd16, 5'd4, 5'd0, 5'd31, 5'd1};

	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        cfg_write_en   = 1'b0;
	logic [CAP_WIDTH-1:0]        cfg_write_data = '0;
	logic                        in_valid       = 1'b0;
	logic                        mode           = MODE_GET;
	logic [LKVC_KEY_WIDTH-1:0]   key            = '0;
	logic [LKVC_VALUE_WIDTH-1:0] value          = '0;
	logic                        out_ready      = 1'b0;
	logic                        in_ready;
	logic                        out_valid;
	logic                        hit;
	logic [LKVC_VALUE_WIDTH-1:0] read_value;
	logic                        evicted;
	logic [LKVC_KEY_WIDTH-1:0]   evicted_key;
	int                          failures;
	int                          pending;
	int unsigned                 sender_idle_pct = 0;
	int unsigned                 stall_pct       = 0;
	int unsigned                 holds_asked     = 0;
	int unsigned                 holds_served    = 0;
	int unsigned                 quiet_cycles    = 0;

	lru_key_value_cache_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.read_value     (read_value),
		.evicted        (evicted),
		.evicted_key    (evicted_key)
	);

	lru_key_value_cache_core_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic offer(
		input logic                        op,
		input logic [LKVC_KEY_WIDTH-1:0]   k,
		input logic [LKVC_VALUE_WIDTH-1:0] v
	);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		key <= k;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted result beat has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
		drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= cap;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [CAP_WIDTH-1:0] cap, input pace_t pace);
		logic [LKVC_KEY_WIDTH-1:0] base;
		logic [LKVC_KEY_WIDTH-1:0] k;
		logic                      op;
		int unsigned               span;
		write_capacity(cap);
		sender_idle_pct = (pace == PACE_SENDER_IDLE) ? 85 : ((pace == PACE_BOTH) ? 12 : 0);
		stall_pct = (pace == PACE_RECEIVER_STALL) ? 85 : ((pace == PACE_BOTH) ? 12 : 0);
		// Keys mostly come from a small window around a random base so that hits,
		// updates and evictions all happen; the odd one is drawn from the whole range.
		base = LKVC_KEY_WIDTH'($urandom);
		span = cap + cap / 2 + 2;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			op = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
			if ($urandom_range(0, 9) == 0)
				k = LKVC_KEY_WIDTH'($urandom);
			else
				k = base ^ LKVC_KEY_WIDTH'($urandom_range(0, span - 1));
			offer(op, k, $urandom);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of key and value, get hit and miss, put update, ignored get value.
		offer(MODE_PUT, 16'h0000, 32'h0000_0000);
		offer(MODE_PUT, 16'hFFFF, 32'hFFFF_FFFF);
		offer(MODE_GET, 16'h0000, 32'h0000_0000);
		offer(MODE_GET, 16'hFFFF, 32'h0000_0000);
		offer(MODE_GET, 16'h1234, 32'hFFFF_FFFF);
		offer(MODE_PUT, 16'h0000, 32'hA5A5_A5A5);
		offer(MODE_GET, 16'h0000, 32'h1234_5678);
		offer(MODE_PUT, 16'h5A5A, 32'h5A5A_5A5A);

		// Capacity lowered below the number of lines held: each put miss swaps one out.
		write_capacity(5'd2);
		offer(MODE_PUT, 16'h0001, 32'h0000_0001);
		offer(MODE_PUT, 16'h0002, 32'h0000_0002);
		offer(MODE_GET, 16'h0001, 32'h0000_0000);
		offer(MODE_PUT, 16'h0003, 32'h0000_0003);
		offer(MODE_GET, 16'hFFFF, 32'h0000_0000);

		// A capacity of zero acts as one.
		write_capacity(5'd0);
		offer(MODE_PUT, 16'h0004, 32'h8000_0000);
		offer(MODE_PUT, 16'h0004, 32'h7FFF_FFFF);
		offer(MODE_GET, 16'h0004, 32'h0000_0000);

		// Oversized capacity saturates; the result side holds off while puts keep
		// coming, so the pipeline fills and the access channel stalls.
		write_capacity(5'd31);
		holds_asked++;
		for (int i = 0; i < BURST_ITEMS; i++)
			offer(MODE_PUT, LKVC_KEY_WIDTH'(16'h0100 + i), $urandom);

		for (int p = 0; p < PHASES; p++)
			run_phase(PHASE_CAPS[p*CAP_WIDTH +: CAP_WIDTH], pace_t'(p % 4));

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
